// ----- hdl/sus_pkg.sv -----
// Package for the sorted unique set: sizes, controller command and status types.
// Used by sus_ctrl, sus_datapath and sorted_unique_set.
package sus_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef struct packed {
        logic             load_item;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_sel_value;
        logic             out_load;
        logic             out_is_count;
        logic             out_last;
        logic             out_dropped;
        logic [CNT_W-1:0] count;
    } sus_cmd_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic out_free;
    } sus_status_t;

endpackage

// ----- hdl/sus_datapath.sv -----
// Datapath of the sorted unique set: entry memory, operand register, compare
// and result register. Depends on sus_pkg; driven by sus_ctrl commands.
module sus_datapath
    import sus_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sus_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] in_value,
    output sus_status_t              status,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    logic signed [DATA_W-1:0] entries_mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] m_item_reg;
    logic [1:0]               m_user_reg;
    logic                     m_last_reg;
    logic signed [DATA_W-1:0] out_item;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            entries_mem[cmd.wr_addr] <= cmd.wr_sel_value ? value_reg : rd_data_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= entries_mem[cmd.rd_addr];
        end
        if (cmd.load_item) begin
            value_reg <= in_value;
        end
    end

    assign status.lt       = rd_data_reg < value_reg;
    assign status.eq       = rd_data_reg == value_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    assign out_item = cmd.out_is_count ? signed'(DATA_W'(cmd.count)) : rd_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_item_reg <= out_item;
            m_user_reg <= {cmd.out_dropped, cmd.out_is_count};
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_item_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hdl/sus_ctrl.sv -----
// Controller of the sorted unique set: search, shift, insert and readout
// sequencing with the entry counters. Depends on sus_pkg; drives sus_datapath.
module sus_ctrl
    import sus_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_action,
    input  sus_status_t status,
    output sus_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_SHIFT_UP = 7'b0000100,
        ST_PUT      = 7'b0001000,
        ST_SHIFT_DN = 7'b0010000,
        ST_EMIT_CNT = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } sus_state_t;

    sus_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             act_reg, act_next;
    logic             drop_reg, drop_next;

    logic             dec_en;
    logic             dec_found;
    logic             dec_act;
    logic [CNT_W-1:0] dec_pos;
    logic [CNT_W-1:0] dec_pos_p1;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] cnt_m1;

    assign idx_p1     = idx_reg + CNT_W'(1);
    assign idx_m1     = idx_reg - CNT_W'(1);
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign dec_pos_p1 = dec_pos + CNT_W'(1);
    assign s_tready   = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        act_next   = act_reg;
        drop_next  = drop_reg;
        dec_en     = 1'b0;
        dec_found  = 1'b0;
        dec_pos    = pos_reg;
        dec_act    = act_reg;
        cmd        = '0;
        cmd.count  = cnt_reg;
        cmd.rd_addr = idx_reg[IDX_W-1:0];
        cmd.wr_addr = pos_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                dec_act = s_action;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    act_next      = s_action;
                    drop_next     = 1'b0;
                    pos_next      = '0;
                    if (cnt_reg == '0) begin
                        dec_en  = 1'b1;
                        dec_pos = '0;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        idx_next    = CNT_W'(1);
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.lt) begin
                    pos_next = pos_reg + CNT_W'(1);
                    if (idx_reg == cnt_reg) begin
                        dec_en  = 1'b1;
                        dec_pos = cnt_reg;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_reg[IDX_W-1:0];
                        idx_next    = idx_p1;
                    end
                end else begin
                    dec_en    = 1'b1;
                    dec_pos   = pos_reg;
                    dec_found = status.eq;
                end
            end
            ST_SHIFT_UP: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_p1[IDX_W-1:0];
                if (idx_reg == pos_reg) begin
                    state_next = ST_PUT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_m1[IDX_W-1:0];
                    idx_next    = idx_m1;
                end
            end
            ST_PUT: begin
                cmd.wr_en        = 1'b1;
                cmd.wr_addr      = pos_reg[IDX_W-1:0];
                cmd.wr_sel_value = 1'b1;
                cnt_next         = cnt_reg + CNT_W'(1);
                state_next       = ST_EMIT_CNT;
            end
            ST_SHIFT_DN: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_m1[IDX_W-1:0];
                if (idx_reg == cnt_m1) begin
                    cnt_next   = cnt_m1;
                    state_next = ST_EMIT_CNT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_p1[IDX_W-1:0];
                    idx_next    = idx_p1;
                end
            end
            ST_EMIT_CNT: begin
                if (status.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_is_count = 1'b1;
                    cmd.out_last     = cnt_reg == '0;
                    cmd.out_dropped  = drop_reg;
                    if (cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = '0;
                        idx_next    = '0;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_last    = idx_reg == cnt_m1;
                    cmd.out_dropped = drop_reg;
                    if (idx_reg == cnt_m1) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_p1[IDX_W-1:0];
                        idx_next    = idx_p1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (dec_en) begin
            pos_next = dec_pos;
            if (dec_act == ACT_INSERT) begin
                if (dec_found) begin
                    state_next = ST_EMIT_CNT;
                end else if (cnt_reg == CNT_W'(CAPACITY)) begin
                    drop_next  = 1'b1;
                    state_next = ST_EMIT_CNT;
                end else if (dec_pos == cnt_reg) begin
                    state_next = ST_PUT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = cnt_m1[IDX_W-1:0];
                    idx_next    = cnt_m1;
                    state_next  = ST_SHIFT_UP;
                end
            end else begin
                if (!dec_found) begin
                    state_next = ST_EMIT_CNT;
                end else if (dec_pos == cnt_m1) begin
                    cnt_next   = cnt_m1;
                    state_next = ST_EMIT_CNT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = dec_pos_p1[IDX_W-1:0];
                    idx_next    = dec_pos_p1;
                    state_next  = ST_SHIFT_DN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        act_reg <= act_next;
    end

endmodule

// ----- hdl/sorted_unique_set.sv -----
// Top level of the sorted unique set: controller plus datapath.
// Depends on sus_pkg, sus_ctrl and sus_datapath.
//
// Usage: each slave transaction carries one request, s_tuser = action
// (0 insert, 1 delete) and s_tdata = signed value. For every request the
// master channel returns the entry count (m_tuser[0] = 1) followed by each
// stored entry in ascending order; m_tlast marks the final transaction and
// m_tuser[1] flags an insert refused because the store held CAPACITY entries.
// A request is taken only when the previous one has been fully handed to the
// result register. With n entries stored, the search reads one entry per
// cycle, then an insert or delete moves up to n entries at one per cycle
// through the one read and one write port of the entry memory, an insert
// places the value, and readout presents n + 1 transactions at one per cycle
// while the receiver accepts them. A stalled receiver holds the result
// register and pauses readout without loss. Reset empties the store at once;
// entry contents are not cleared.
module sorted_unique_set
    import sus_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                     s_tuser,   // [0] action
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,   // [31:0] item
    output logic [1:0]               m_tuser,   // [0] is_count, [1] dropped
    output logic                     m_tlast
);

    sus_cmd_t    cmd;
    sus_status_t status;

    sus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    sus_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_value (s_tdata),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in progress");

    a_port_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
        else $error("memory read and write at same address");

endmodule
